### sv/cv2d_pkg.sv
package cv2d_pkg;

  // Default values for the top-level parameters.
  localparam int KernelWidthDef  = 3;
  localparam int KernelHeightDef = 3;
  localparam int MaxWidthDef     = 1024;

  // Fixed field widths.
  localparam int PixW         = 16;
  localparam int ImageWidthW  = 11;
  localparam int ImageHeightW = 16;
  localparam int CfgDataW     = 64;
  localparam int CfgIndexW    = 3;
  localparam int NumKernRows  = 4;

  // Register reset values.
  localparam logic [ImageWidthW-1:0]  ImageWidthRst  = ImageWidthW'(1024);
  localparam logic [ImageHeightW-1:0] ImageHeightRst = ImageHeightW'(1024);

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgKernelRow0  = 3'd2,
    CfgKernelRow1  = 3'd3,
    CfgKernelRow2  = 3'd4,
    CfgKernelRow3  = 3'd5
  } cv2d_cfg_idx_e;

  // Packed kernel rows, four signed 16-bit coefficients each, column 0 in low bits.
  typedef logic [NumKernRows-1:0][CfgDataW-1:0] cv2d_kernel_t;

  // Position marks that travel with a result.
  typedef struct packed {
    logic eor;
    logic eof;
  } cv2d_flags_t;

endpackage

### sv/cv2d_ram.sv
module cv2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port; read data holds when not reading.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/cv2d_window.sv
module cv2d_window
  import cv2d_pkg::*;
#(
  parameter int KernelWidth  = KernelWidthDef,
  parameter int KernelHeight = KernelHeightDef,
  parameter int MaxWidth     = MaxWidthDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [ImageWidthW-1:0]                    image_width_i,
  input  logic [ImageHeightW-1:0]                   image_height_i,
  input  logic                                      pixel_valid_i,
  output logic                                      pixel_ready_o,
  input  logic [PixW-1:0]                           pixel_i,
  output logic                                      win_valid_o,
  input  logic                                      win_ready_i,
  output logic [KernelHeight*KernelWidth-1:0][PixW-1:0] win_pixels_o,
  output cv2d_flags_t                               win_flags_o
);

  localparam int ColW   = $clog2(MaxWidth);
  localparam int CmpW   = ($clog2(MaxWidth + 1) > ImageWidthW) ?
                          $clog2(MaxWidth + 1) : ImageWidthW;
  localparam int LsRows = (KernelHeight > 1) ? KernelHeight - 1 : 1;
  localparam int LsW    = PixW * LsRows;
  localparam int WinN   = KernelHeight * KernelWidth;

  logic [ColW-1:0]         col_q, col_d;
  logic [ImageHeightW-1:0] row_q, row_d;
  logic                    a_valid_q, a_emit_q, a_emit_d;
  cv2d_flags_t             a_flags_q, a_flags_d;
  logic [PixW-1:0]         a_pixel_q;
  logic [ColW-1:0]         a_addr_q;
  logic                    fwd_q, fwd_d;
  logic [LsW-1:0]          fwd_data_q;
  logic [WinN-1:0][PixW-1:0] win_q, win_d;

  logic [CmpW-1:0]         eff_w, col_inc;
  logic [ImageHeightW-1:0] eff_h;
  logic [ImageHeightW:0]   row_inc;
  logic                    last_col, last_row;
  logic                    accept, a_go;
  logic [LsW-1:0]          ram_rdata, rd_eff, ls_wdata;
  logic [KernelHeight-1:0][PixW-1:0] col_px;

  // Effective frame size: zero acts as one, width saturates to the store depth.
  always_comb begin
    eff_w = CmpW'(image_width_i);
    if (image_width_i == '0) begin
      eff_w = CmpW'(1);
    end else if (eff_w > CmpW'(MaxWidth)) begin
      eff_w = CmpW'(MaxWidth);
    end
    eff_h = (image_height_i == '0) ? ImageHeightW'(1) : image_height_i;
  end

  // Raster position tests for the pixel at the input.
  assign col_inc  = CmpW'(col_q) + CmpW'(1);
  assign row_inc  = {1'b0, row_q} + (ImageHeightW + 1)'(1);
  assign last_col = (col_inc >= eff_w);
  assign last_row = (row_inc >= {1'b0, eff_h});

  always_comb begin
    a_emit_d = (col_inc >= CmpW'(KernelWidth)) &&
               (row_inc >= (ImageHeightW + 1)'(KernelHeight)) &&
               (CmpW'(col_q) < eff_w) && (row_q < eff_h);
    a_flags_d.eor = last_col;
    a_flags_d.eof = last_col && last_row;
  end

  // Handshake: stage A drains unless it holds a result the multiplier cannot take.
  assign a_go          = a_valid_q && (!a_emit_q || win_ready_i);
  assign pixel_ready_o = !a_valid_q || a_go;
  assign accept        = pixel_valid_i && pixel_ready_o;

  // Column and row counters.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_inc[ImageHeightW-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
    end
  end

  // Line-store read data, with the write of the previous request forwarded.
  assign rd_eff = fwd_q ? fwd_data_q : ram_rdata;

  // New window column and the shifted column written back to the line store.
  always_comb begin
    ls_wdata = '0;
    for (int ky = 0; ky < KernelHeight - 1; ky++) begin
      col_px[ky] = rd_eff[ky*PixW +: PixW];
    end
    col_px[KernelHeight-1] = a_pixel_q;
    for (int ky = 0; ky < KernelHeight - 1; ky++) begin
      ls_wdata[ky*PixW +: PixW] = col_px[ky+1];
    end
  end

  // Window shifts left by one column and takes the new column on the right.
  always_comb begin
    for (int ky = 0; ky < KernelHeight; ky++) begin
      for (int kx = 0; kx < KernelWidth; kx++) begin
        if (kx < KernelWidth - 1) begin
          win_d[ky*KernelWidth+kx] = win_q[ky*KernelWidth+kx+1];
        end else begin
          win_d[ky*KernelWidth+kx] = col_px[ky];
        end
      end
    end
  end

  // A same-address read and write in one cycle takes the written data.
  assign fwd_d = a_go && (a_addr_q == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      a_emit_q  <= 1'b0;
      a_flags_q <= '0;
      fwd_q     <= 1'b0;
      win_q     <= '0;
    end else begin
      if (pixel_ready_o) begin
        a_valid_q <= pixel_valid_i;
      end
      if (accept) begin
        col_q     <= col_d;
        row_q     <= row_d;
        a_emit_q  <= a_emit_d;
        a_flags_q <= a_flags_d;
        fwd_q     <= fwd_d;
      end
      if (a_go) begin
        win_q <= win_d;
      end
    end
  end

  // Payload registers of stage A.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pixel_q  <= pixel_i;
      a_addr_q   <= col_q;
      fwd_data_q <= ls_wdata;
    end
  end

  // Line store holding the previous rows, one word per column.
  if (KernelHeight > 1) begin : g_ls
    cv2d_ram #(
      .Width(LsW),
      .Depth(MaxWidth)
    ) u_line_store (
      .clk_i  (clk_i),
      .we_i   (a_go),
      .waddr_i(a_addr_q),
      .wdata_i(ls_wdata),
      .re_i   (accept),
      .raddr_i(col_q),
      .rdata_o(ram_rdata)
    );
  end else begin : g_no_ls
    assign ram_rdata = '0;
  end

  assign win_valid_o  = a_valid_q && a_emit_q;
  assign win_pixels_o = win_d;
  assign win_flags_o  = a_flags_q;

endmodule

### sv/cv2d_mac.sv
module cv2d_mac
  import cv2d_pkg::*;
#(
  parameter int KernelWidth  = KernelWidthDef,
  parameter int KernelHeight = KernelHeightDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  cv2d_kernel_t                              kernel_i,
  input  logic                                      win_valid_i,
  output logic                                      win_ready_o,
  input  logic [KernelHeight*KernelWidth-1:0][PixW-1:0] win_pixels_i,
  input  cv2d_flags_t                               win_flags_i,
  output logic                                      result_valid_o,
  input  logic                                      result_ready_i,
  output logic [PixW-1:0]                           result_value_o,
  output logic                                      end_of_row_o,
  output logic                                      end_of_frame_o
);

  localparam int WinN = KernelHeight * KernelWidth;

  logic [WinN-1:0][PixW-1:0]   prod_d, prod_q;
  logic [WinN-1:0][2*PixW-1:0] prod_full;
  logic                        b_valid_q, b_go, o_valid_q;
  cv2d_flags_t                 b_flags_q, o_flags_q;
  logic [PixW-1:0]             sum, o_value_q;

  // Stage B drains into the output register when it is empty or being read.
  assign b_go        = b_valid_q && (!o_valid_q || result_ready_i);
  assign win_ready_o = !b_valid_q || b_go;

  // One multiplier per window tap; products wrap to 16 bits.
  always_comb begin
    for (int ky = 0; ky < KernelHeight; ky++) begin
      for (int kx = 0; kx < KernelWidth; kx++) begin
        prod_full[ky*KernelWidth+kx] = kernel_i[ky][kx*PixW +: PixW] *
                                       win_pixels_i[ky*KernelWidth+kx];
        prod_d[ky*KernelWidth+kx]    = prod_full[ky*KernelWidth+kx][PixW-1:0];
      end
    end
  end

  // Wrapping sum over the registered products.
  always_comb begin
    sum = '0;
    for (int i = 0; i < WinN; i++) begin
      sum = sum + prod_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (win_ready_o) begin
        b_valid_q <= win_valid_i;
      end
      if (!o_valid_q || result_ready_i) begin
        o_valid_q <= b_valid_q;
      end
    end
  end

  // Product and result payload registers.
  always_ff @(posedge clk_i) begin
    if (win_valid_i && win_ready_o) begin
      prod_q    <= prod_d;
      b_flags_q <= win_flags_i;
    end
    if (b_go) begin
      o_value_q <= sum;
      o_flags_q <= b_flags_q;
    end
  end

  assign result_valid_o = o_valid_q;
  assign result_value_o = o_value_q;
  assign end_of_row_o   = o_flags_q.eor;
  assign end_of_frame_o = o_flags_q.eof;

endmodule

### sv/conv2d_valid_int16_stream.sv
// Throughput: one pixel per cycle unless results stall, set by the line store,
// which takes one read and one write each cycle; a write-to-read hit on the same
// column is forwarded. A result passes stage A, stage B and the output register.
// Reset: counters, window and kernel clear, width and height return to 1024.
// The line store is not cleared; no result reads an entry before it was written.
module conv2d_valid_int16_stream
  import cv2d_pkg::*;
#(
  parameter int KernelWidth  = KernelWidthDef,
  parameter int KernelHeight = KernelHeightDef,
  parameter int MaxWidth     = MaxWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 pixel_valid_i,
  output logic                 pixel_ready_o,
  input  logic [PixW-1:0]      pixel_i,
  output logic                 result_valid_o,
  input  logic                 result_ready_i,
  output logic [PixW-1:0]      result_value_o,
  output logic                 end_of_row_o,
  output logic                 end_of_frame_o
);

  localparam int WinN = KernelHeight * KernelWidth;

  logic [ImageWidthW-1:0]    image_width_q;
  logic [ImageHeightW-1:0]   image_height_q;
  cv2d_kernel_t              kernel_q;
  logic                      win_valid, win_ready;
  logic [WinN-1:0][PixW-1:0] win_pixels;
  cv2d_flags_t               win_flags;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= ImageWidthRst;
      image_height_q <= ImageHeightRst;
      kernel_q       <= '0;
    end else if (cfg_we_i) begin
      case (cv2d_cfg_idx_e'(cfg_index_i))
        CfgImageWidth:  image_width_q  <= cfg_wdata_i[ImageWidthW-1:0];
        CfgImageHeight: image_height_q <= cfg_wdata_i[ImageHeightW-1:0];
        CfgKernelRow0:  kernel_q[0]    <= cfg_wdata_i;
        CfgKernelRow1:  kernel_q[1]    <= cfg_wdata_i;
        CfgKernelRow2:  kernel_q[2]    <= cfg_wdata_i;
        CfgKernelRow3:  kernel_q[3]    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Line store, raster counters and window.
  cv2d_window #(
    .KernelWidth (KernelWidth),
    .KernelHeight(KernelHeight),
    .MaxWidth    (MaxWidth)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .image_width_i (image_width_q),
    .image_height_i(image_height_q),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .win_valid_o   (win_valid),
    .win_ready_i   (win_ready),
    .win_pixels_o  (win_pixels),
    .win_flags_o   (win_flags)
  );

  // Multiply, sum and output register.
  cv2d_mac #(
    .KernelWidth (KernelWidth),
    .KernelHeight(KernelHeight)
  ) u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kernel_i      (kernel_q),
    .win_valid_i   (win_valid),
    .win_ready_o   (win_ready),
    .win_pixels_i  (win_pixels),
    .win_flags_i   (win_flags),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .result_value_o(result_value_o),
    .end_of_row_o  (end_of_row_o),
    .end_of_frame_o(end_of_frame_o)
  );

endmodule

### tb/conv2d_valid_int16_stream_chk.sv
// Watches the pixel, result and register channels of the convolution block, predicts
// each windowed sum and compares the results in order against the predictions.
module conv2d_valid_int16_stream_chk
  import cv2d_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 pixel_valid_i,
  input  logic                 pixel_ready_i,
  input  logic [PixW-1:0]      pixel_i,
  input  logic                 result_valid_i,
  input  logic                 result_ready_i,
  input  logic [PixW-1:0]      result_value_i,
  input  logic                 end_of_row_i,
  input  logic                 end_of_frame_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int KernelWidth  = KernelWidthDef;
  localparam int KernelHeight = KernelHeightDef;
  localparam int MaxWidth     = MaxWidthDef;
  localparam int MaxReports   = 10;

  typedef struct packed {
    logic [PixW-1:0] value;
    logic            eor;
    logic            eof;
  } conv_sum_t;

  // Shadow of the block's registers and datapath state.
  logic [ImageWidthW-1:0]  width_q;
  logic [ImageHeightW-1:0] height_q;
  cv2d_kernel_t            kernel_q;
  logic [PixW-1:0]         line_mem [KernelHeight-1][MaxWidth];
  logic [PixW-1:0]         win [KernelHeight][KernelWidth];
  int unsigned             col_cnt;
  int unsigned             row_cnt;

  conv_sum_t               sums_due [$];
  int                      mismatch_count;

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_q;
    if (w == 0) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = height_q;
    if (h == 0) h = 1;
    return h;
  endfunction

  // Shifts one pixel through the line stores and the window, queues the windowed sum
  // when the window lies inside the frame, and advances the raster position.
  task automatic accept_pixel(input logic [PixW-1:0] px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     c;
    logic [PixW-1:0] column [KernelHeight];
    logic [PixW-1:0] acc;
    logic [2*PixW-1:0] prod;
    conv_sum_t       sum;
    w = active_width();
    h = active_height();
    c = col_cnt % MaxWidth;

    // New window column: older rows come from the line stores.
    for (int ky = 0; ky < KernelHeight - 1; ky++) column[ky] = line_mem[ky][c];
    column[KernelHeight-1] = px;
    for (int ky = 0; ky < KernelHeight - 1; ky++) line_mem[ky][c] = column[ky+1];

    for (int ky = 0; ky < KernelHeight; ky++) begin
      for (int kx = 0; kx < KernelWidth - 1; kx++) win[ky][kx] = win[ky][kx+1];
      win[ky][KernelWidth-1] = column[ky];
    end

    if (col_cnt + 1 >= KernelWidth && row_cnt + 1 >= KernelHeight &&
        col_cnt < w && row_cnt < h) begin
      // Products and partial sums all wrap at 16 bits.
      acc = '0;
      for (int ky = 0; ky < KernelHeight; ky++) begin
        for (int kx = 0; kx < KernelWidth; kx++) begin
          prod = kernel_q[ky][PixW*kx +: PixW] * win[ky][kx];
          acc  = acc + prod[PixW-1:0];
        end
      end
      sum.value = acc;
      sum.eor   = (col_cnt + 1 >= w);
      sum.eof   = sum.eor && (row_cnt + 1 >= h);
      sums_due.push_back(sum);
    end

    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endtask

  // Compares one result request with the oldest predicted sum.
  task automatic check_result();
    conv_sum_t want;
    if (sums_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
        $display("%0t: unexpected result: value %h eor %b eof %b",
                 $time, result_value_i, end_of_row_i, end_of_frame_i);
      end
    end else begin
      want = sums_due.pop_front();
      if (want.value !== result_value_i || want.eor !== end_of_row_i ||
          want.eof !== end_of_frame_i) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("%0t: result mismatch: value %h/%h eor %b/%b eof %b/%b (expected/actual)",
                   $time, want.value, result_value_i, want.eor, end_of_row_i,
                   want.eof, end_of_frame_i);
        end
      end
    end
  endtask

  // Results are checked before the pixel of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = ImageWidthRst;
      height_q = ImageHeightRst;
      kernel_q = '0;
      for (int ky = 0; ky < KernelHeight; ky++) begin
        for (int kx = 0; kx < KernelWidth; kx++) win[ky][kx] = '0;
      end
      for (int ky = 0; ky < KernelHeight - 1; ky++) begin
        for (int i = 0; i < MaxWidth; i++) line_mem[ky][i] = '0;
      end
      col_cnt = 0;
      row_cnt = 0;
      sums_due.delete();
      mismatch_count = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (result_valid_i && result_ready_i) check_result();
      if (cfg_we_i) begin
        case (cv2d_cfg_idx_e'(cfg_index_i))
          CfgImageWidth:  width_q     = cfg_wdata_i[ImageWidthW-1:0];
          CfgImageHeight: height_q    = cfg_wdata_i[ImageHeightW-1:0];
          CfgKernelRow0:  kernel_q[0] = cfg_wdata_i;
          CfgKernelRow1:  kernel_q[1] = cfg_wdata_i;
          CfgKernelRow2:  kernel_q[2] = cfg_wdata_i;
          CfgKernelRow3:  kernel_q[3] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (pixel_valid_i && pixel_ready_i) accept_pixel(pixel_i);
      pending_o    <= sums_due.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

### tb/tb_conv2d_valid_int16_stream.sv
module tb_conv2d_valid_int16_stream;
  import cv2d_pkg::*;

  localparam int NumRegs      = int'(CfgKernelRow3) + 1;
  // Settle time after the last predicted result; it also covers pixels that give no result.
  localparam int SettleCycles = 6;
  localparam int RandomItems  = 860;

  typedef enum int {
    ReadyAlways,
    ReadyMostly,
    ReadyPattern,
    ReadyRarely
  } ready_mode_e;

  logic            clk          = 1'b0;
  logic            rst_n        = 1'b0;
  logic            cfg_we       = 1'b0;
  cv2d_cfg_idx_e   cfg_index    = CfgImageWidth;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic            pixel_valid  = 1'b0;
  logic            pixel_ready;
  logic [PixW-1:0] pixel        = '0;
  logic            result_valid;
  logic            result_ready = 1'b0;
  logic [PixW-1:0] result_value;
  logic            end_of_row;
  logic            end_of_frame;
  int              fail_count;
  int              sums_pending;

  // Register values as last written, and the raster position of the next pixel.
  logic [CfgDataW-1:0] reg_shadow [NumRegs];
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;
  int unsigned     items_sent = 0;
  int              burst_left = 0;

  ready_mode_e     ready_mode = ReadyAlways;
  int unsigned     ready_left = 0;
  logic [7:0]      ready_pattern = 8'hFF;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  conv2d_valid_int16_stream DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .pixel_valid_i  (pixel_valid),
    .pixel_ready_o  (pixel_ready),
    .pixel_i        (pixel),
    .result_valid_o (result_valid),
    .result_ready_i (result_ready),
    .result_value_o (result_value),
    .end_of_row_o   (end_of_row),
    .end_of_frame_o (end_of_frame)
  );

  conv2d_valid_int16_stream_chk u_conv_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .pixel_valid_i  (pixel_valid),
    .pixel_ready_i  (pixel_ready),
    .pixel_i        (pixel),
    .result_valid_i (result_valid),
    .result_ready_i (result_ready),
    .result_value_i (result_value),
    .end_of_row_i   (end_of_row),
    .end_of_frame_i (end_of_frame),
    .fail_count_o   (fail_count),
    .pending_o      (sums_pending)
  );

  // The receiver switches between stall modes in stretches of random length.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode    = ready_mode_e'($urandom_range(0, 3));
      ready_left    = $urandom_range(8, 120);
      ready_pattern = 8'($urandom) | 8'h01;
    end else begin
      ready_left--;
    end
    case (ready_mode)
      ReadyAlways: result_ready <= 1'b1;
      ReadyMostly: result_ready <= ($urandom_range(0, 3) != 0);
      ReadyPattern: begin
        result_ready  <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      end
      default: result_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(reg_shadow[CfgImageWidth][ImageWidthW-1:0]);
    if (w == 0) w = 1;
    if (w > MaxWidthDef) w = MaxWidthDef;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = 32'(reg_shadow[CfgImageHeight][ImageHeightW-1:0]);
    if (h == 0) h = 1;
    return h;
  endfunction

  function automatic logic [PixW-1:0] pick_pixel(input bit extremes_only);
    if (extremes_only || $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'hFFFF;
        3:       return 16'h0000;
        4:       return 16'h0001;
        default: return 16'hAAAA;
      endcase
    end
    return PixW'($urandom);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_kernel_row();
    logic [CfgDataW-1:0] row;
    case ($urandom_range(0, 5))
      0: row = {4{16'h8000}};
      1: row = {4{16'h7FFF}};
      2: begin
        // Small signed coefficients keep the sums easy to follow.
        for (int k = 0; k < 4; k++) row[PixW*k +: PixW] = PixW'($urandom_range(0, 6)) - 16'd3;
      end
      default: row = {$urandom, $urandom};
    endcase
    return row;
  endfunction

  // Offers one pixel request, starting a new burst after a random gap when one ends.
  task automatic drive_pixel(input logic [PixW-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pixel_valid <= 1'b1;
    pixel       <= value;
    do @(posedge clk); while (!pixel_ready);
  endtask

  // Sends at least count pixels; with align set it goes on to the end of the frame.
  task automatic send_pixels(input int unsigned count, input bit align, input bit extremes_only);
    int unsigned sent;
    sent = 0;
    while (sent < count || (align && (col_pos != 0 || row_pos != 0))) begin
      drive_pixel(pick_pixel(extremes_only));
      sent++;
      if (col_pos + 1 >= eff_width()) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= eff_height()) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    end
    items_sent += sent;
  endtask

  // Waits until every predicted result has been taken and the pipeline is empty.
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_regs(input bit [NumRegs-1:0] mask);
    drain();
    for (int i = 0; i < NumRegs; i++) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= cv2d_cfg_idx_e'(i);
        cfg_wdata <= reg_shadow[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned     random_goal;
    bit [NumRegs-1:0] mask;
    bit              at_origin;
    reg_shadow[CfgImageWidth]  = CfgDataW'(ImageWidthRst);
    reg_shadow[CfgImageHeight] = CfgDataW'(ImageHeightRst);
    for (int i = int'(CfgKernelRow0); i < NumRegs; i++) reg_shadow[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A few pixels at the reset geometry, then the width drops below the current column.
    send_pixels(5, 1'b0, 1'b1);
    reg_shadow[CfgImageWidth]  = CfgDataW'(4);
    reg_shadow[CfgImageHeight] = CfgDataW'(3);
    reg_shadow[CfgKernelRow0]  = {4{16'h7FFF}};
    reg_shadow[CfgKernelRow1]  = {4{16'h8000}};
    reg_shadow[CfgKernelRow2]  = {4{16'hFFFF}};
    reg_shadow[CfgKernelRow3]  = 64'h0123_4567_89AB_CDEF;
    load_regs('1);
    send_pixels(9, 1'b1, 1'b1);
    send_pixels(12, 1'b1, 1'b1);

    // Width above the maximum saturates to the full line: one full row moves the
    // raster to the next row, and the frame then closes at a narrow width.
    reg_shadow[CfgImageWidth]  = CfgDataW'(2047);
    reg_shadow[CfgKernelRow0]  = pick_kernel_row();
    reg_shadow[CfgKernelRow1]  = pick_kernel_row();
    reg_shadow[CfgKernelRow2]  = pick_kernel_row();
    load_regs(NumRegs'((1 << CfgImageWidth) | (1 << CfgKernelRow0) |
                       (1 << CfgKernelRow1) | (1 << CfgKernelRow2)));
    send_pixels(MaxWidthDef, 1'b0, 1'b0);
    reg_shadow[CfgImageWidth]  = CfgDataW'(8);
    load_regs(NumRegs'(1 << CfgImageWidth));
    send_pixels(16, 1'b1, 1'b0);

    // Zero sizes act as one, and frames smaller than the kernel give no results.
    reg_shadow[CfgImageWidth]  = CfgDataW'(0);
    reg_shadow[CfgImageHeight] = CfgDataW'(0);
    load_regs(NumRegs'((1 << CfgImageWidth) | (1 << CfgImageHeight)));
    send_pixels(6, 1'b1, 1'b0);
    reg_shadow[CfgImageWidth]  = CfgDataW'(2);
    reg_shadow[CfgImageHeight] = CfgDataW'(2);
    load_regs(NumRegs'((1 << CfgImageWidth) | (1 << CfgImageHeight)));
    send_pixels(8, 1'b1, 1'b0);

    // Tallest frame, cut short by a height below the current row.
    reg_shadow[CfgImageWidth]  = CfgDataW'(5);
    reg_shadow[CfgImageHeight] = CfgDataW'(65535);
    load_regs(NumRegs'((1 << CfgImageWidth) | (1 << CfgImageHeight)));
    send_pixels(40, 1'b0, 1'b0);
    reg_shadow[CfgImageHeight] = CfgDataW'(4);
    load_regs(NumRegs'(1 << CfgImageHeight));
    send_pixels(20, 1'b1, 1'b0);

    // Random phases. The width only grows at a frame start, so every line store
    // entry that a result uses has been written in the current geometry.
    random_goal = items_sent + RandomItems;
    while (items_sent < random_goal) begin
      mask      = NumRegs'($urandom);
      at_origin = (col_pos == 0 && row_pos == 0);
      if (mask[CfgImageWidth]) begin
        reg_shadow[CfgImageWidth] = at_origin ? CfgDataW'($urandom_range(0, 24))
                                              : CfgDataW'($urandom_range(0, eff_width()));
      end
      if (mask[CfgImageHeight]) begin
        reg_shadow[CfgImageHeight] = CfgDataW'($urandom_range(0, 10));
      end
      for (int i = int'(CfgKernelRow0); i < NumRegs; i++) begin
        if (mask[i]) reg_shadow[i] = pick_kernel_row();
      end
      load_regs(mask);
      send_pixels($urandom_range(1, 150), $urandom_range(0, 3) != 0, 1'b0);
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
